### rtl/escaped_delimiter_tokenizer_defines.svh
// Assertion macros shared by the tokenizer RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ESCAPED_DELIMITER_TOKENIZER_DEFINES_SVH
`define ESCAPED_DELIMITER_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define EDT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define EDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/edt_pkg.sv
// Package for the escaped delimiter tokenizer: types, register indexes
// and sizing constants. Used by every RTL module of the block.
package edt_pkg;

  localparam int unsigned NUM_SLOTS    = 4;
  localparam int unsigned MAX_DELIMS_D = 4;
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned PTR_W        = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W        = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] ESCAPE_BYTE = 8'h5C;

  // Register indexes on the configuration channel
  localparam logic [2:0] REG_DELIM_0     = 3'd0;
  localparam logic [2:0] REG_DELIM_1     = 3'd1;
  localparam logic [2:0] REG_DELIM_2     = 3'd2;
  localparam logic [2:0] REG_DELIM_3     = 3'd3;
  localparam logic [2:0] REG_DELIM_COUNT = 3'd4;
  localparam logic [2:0] REG_STRIP       = 3'd5;

  localparam logic [7:0] DELIM_0_RST = 8'd59;

  typedef struct packed {
    logic [NUM_SLOTS-1:0][7:0] delim;
    logic [2:0]                delim_count;
    logic                      strip_escape;
  } edt_cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       token_end;
    logic       string_end;
    logic       run_last;
  } edt_res_t;

endpackage

### rtl/edt_cfg.sv
// Configuration register file of the tokenizer.
// Depends on edt_pkg.
module edt_cfg #(
  parameter int unsigned MAX_DELIMS = edt_pkg::MAX_DELIMS_D
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [2:0]       wr_index,
  input  logic [7:0]       wr_data,
  output edt_pkg::edt_cfg_t cfg
);
  import edt_pkg::*;

  localparam int unsigned SLOTS = (MAX_DELIMS < NUM_SLOTS) ? MAX_DELIMS : NUM_SLOTS;

  logic [7:0] delim_r [SLOTS];
  logic [2:0] count_r;
  logic       strip_r;

  // Hold one delimiter byte per usable slot
  for (genvar i = 0; i < SLOTS; i++) begin : g_slot
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        delim_r[i] <= (i == 0) ? DELIM_0_RST : 8'd0;
      end else if (wr_en && (wr_index == 3'(i))) begin
        delim_r[i] <= wr_data;
      end
    end
  end

  // Count and strip mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 3'd1;
      strip_r <= 1'b1;
    end else if (wr_en) begin
      if (wr_index == REG_DELIM_COUNT) begin
        count_r <= wr_data[2:0];
      end
      if (wr_index == REG_STRIP) begin
        strip_r <= wr_data[0];
      end
    end
  end

  // Slots beyond the usable range read as zero and are never matched
  always_comb begin
    cfg = '0;
    for (int i = 0; i < SLOTS; i++) begin
      cfg.delim[i] = delim_r[i];
    end
    cfg.delim_count  = count_r;
    cfg.strip_escape = strip_r;
  end

endmodule

### rtl/edt_core.sv
// Per-byte tokenizer decision: escape and token state, up to two result
// words per byte. Depends on edt_pkg and the assertion macro header.
`include "escaped_delimiter_tokenizer_defines.svh"

module edt_core #(
  parameter int unsigned MAX_DELIMS = edt_pkg::MAX_DELIMS_D
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  edt_pkg::edt_cfg_t cfg,
  output logic [1:0]        res_num,
  output edt_pkg::edt_res_t res0,
  output edt_pkg::edt_res_t res1
);
  import edt_pkg::*;

  localparam int unsigned SLOTS = (MAX_DELIMS < NUM_SLOTS) ? MAX_DELIMS : NUM_SLOTS;

  logic       esc_r, esc_nxt;
  logic       tok_r, tok_nxt;
  logic [2:0] n_act;
  logic       hit;

  // Clamp the slot count and match the byte against active slots
  always_comb begin
    n_act = (cfg.delim_count > 3'(SLOTS)) ? 3'(SLOTS) : cfg.delim_count;
    hit   = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if ((3'(i) < n_act) && (cfg.delim[i] == in_byte)) begin
        hit = 1'b1;
      end
    end
  end

  // Decide results and next state for one byte
  always_comb begin
    esc_nxt = esc_r;
    tok_nxt = tok_r;
    res_num = 2'd0;
    res0    = '0;
    res1    = '0;
    if (n_act == 3'd0) begin
      // passthrough: every byte is a token byte
      res_num = 2'd1;
      res0    = '{out_byte: in_byte, byte_valid: 1'b1, token_end: in_last,
                  string_end: in_last, run_last: 1'b1};
      esc_nxt = 1'b0;
      tok_nxt = !in_last;
    end else if ((in_byte == ESCAPE_BYTE) && !esc_r) begin
      if (!in_last) begin
        esc_nxt = 1'b1;
      end else begin
        // dangling backslash at end of string: drop it
        res_num = 2'd1;
        res0    = '{out_byte: 8'd0, byte_valid: 1'b0, token_end: tok_r,
                    string_end: 1'b1, run_last: 1'b1};
        esc_nxt = 1'b0;
        tok_nxt = 1'b0;
      end
    end else if (hit && !esc_r) begin
      // plain delimiter: close an open token
      if (tok_r || in_last) begin
        res_num = 2'd1;
        res0    = '{out_byte: 8'd0, byte_valid: 1'b0, token_end: tok_r,
                    string_end: in_last, run_last: 1'b1};
      end
      tok_nxt = 1'b0;
    end else begin
      // token byte, possibly preceded by its backslash
      esc_nxt = 1'b0;
      tok_nxt = !in_last;
      if (esc_r && !(hit && cfg.strip_escape)) begin
        res_num = 2'd2;
        res0    = '{out_byte: ESCAPE_BYTE, byte_valid: 1'b1, token_end: 1'b0,
                    string_end: 1'b0, run_last: 1'b0};
        res1    = '{out_byte: in_byte, byte_valid: 1'b1, token_end: in_last,
                    string_end: in_last, run_last: 1'b1};
      end else begin
        res_num = 2'd1;
        res0    = '{out_byte: in_byte, byte_valid: 1'b1, token_end: in_last,
                    string_end: in_last, run_last: 1'b1};
      end
    end
  end

  // Advance state only on an accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
      tok_r <= 1'b0;
    end else if (fire) begin
      esc_r <= esc_nxt;
      tok_r <= tok_nxt;
    end
  end

  `EDT_ASSERT_NEXT(a_end_clears, fire && in_last, !esc_r && !tok_r, "state not cleared at string end")
  `EDT_ASSERT_NOW(a_pair_bytes, res_num == 2'd2, res0.byte_valid && res1.byte_valid && !res0.run_last, "bad result pair")
  `EDT_ASSERT_NOW(a_never_three, 1'b1, res_num != 2'd3, "more than two results for one byte")

endmodule

### rtl/edt_fifo.sv
// Result buffer: takes up to two result words a cycle, gives one a cycle while the reader is ready.
// Depends on edt_pkg and the assertion macro header.
`include "escaped_delimiter_tokenizer_defines.svh"

module edt_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_num,
  input  edt_pkg::edt_res_t push0,
  input  edt_pkg::edt_res_t push1,
  output logic              room2,
  output logic              pop_valid,
  input  logic              pop_ready,
  output edt_pkg::edt_res_t pop_word
);
  import edt_pkg::*;

  edt_res_t         mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;
  logic [PTR_W-1:0] wr_ptr_p1;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (cnt_r != '0);
  assign pop_word  = mem_r[rd_ptr_r];
  assign room2     = (cnt_r <= CNT_W'(FIFO_DEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + PTR_W'(1);

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_num);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    cnt_nxt    = cnt_r + CNT_W'(push_num) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the new words
  always_ff @(posedge clk) begin
    if (push_num != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_num == 2'd2) begin
      mem_r[wr_ptr_p1] <= push1;
    end
  end

  `EDT_ASSERT_NOW(a_no_overflow, push_num != 2'd0, room2, "push into a full buffer")
  `EDT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(FIFO_DEPTH), "fill count out of range")
  `EDT_ASSERT_NOW(a_ptr_gap, 1'b1, (wr_ptr_r - rd_ptr_r) == PTR_W'(cnt_r), "pointers and fill count disagree")

endmodule

### rtl/escaped_delimiter_tokenizer.sv
// Escaped delimiter tokenizer, top level: configuration registers, the
// per-byte decision and the result buffer. Depends on edt_pkg.
//
// One string byte is taken per cycle while the buffer has room. Each byte is
// decoded in the cycle it is accepted and gives zero, one or two result
// words, which enter a four-word result buffer and are registered there
// before they reach the output. The output drains one word a cycle while
// out_tready is high, so bytes run at one per cycle while each gives at most
// one word; a byte that gives two words (a backslash kept with the byte it
// escapes) leaves the buffer fuller, which the buffer absorbs. in_tready drops
// while fewer than two buffer words are free. Configuration writes are always taken.
module escaped_delimiter_tokenizer #(
  parameter int unsigned MAX_DELIMS = edt_pkg::MAX_DELIMS_D
) (
  input  logic       clk,
  input  logic       rst_n,
  // string bytes
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // in_last
  // result words
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [2:0] out_tuser,  // [0] byte_valid, [1] token_end, [2] string_end
  output logic       out_tlast,  // run_last
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import edt_pkg::*;

  edt_cfg_t   cfg;
  logic       in_fire;
  logic       room2;
  logic [1:0] res_num;
  logic [1:0] push_num;
  edt_res_t   res0, res1, pop_word;

  assign cfg_ready = 1'b1;
  assign in_tready = room2;
  assign in_fire   = in_tvalid && in_tready;
  assign push_num  = in_fire ? res_num : 2'd0;

  edt_cfg #(.MAX_DELIMS(MAX_DELIMS)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  edt_core #(.MAX_DELIMS(MAX_DELIMS)) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .cfg     (cfg),
    .res_num (res_num),
    .res0    (res0),
    .res1    (res1)
  );

  edt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_num  (push_num),
    .push0     (res0),
    .push1     (res1),
    .room2     (room2),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_word  (pop_word)
  );

  // Unpack the head word onto the stream
  assign out_tdata = pop_word.out_byte;
  assign out_tuser = {pop_word.string_end, pop_word.token_end, pop_word.byte_valid};
  assign out_tlast = pop_word.run_last;

endmodule

### tb/edt_token_checker.sv
// Result checker for the escaped delimiter tokenizer: watches the byte, result
// and configuration channels, predicts every result word and compares it.
// Depends on edt_pkg for the register indexes, the escape byte and the word type.
module edt_token_checker #(
  parameter int unsigned MAX_DELIMS = edt_pkg::MAX_DELIMS_D
) (
  input  logic       clk,
  input  logic       rst_n,
  // string bytes
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // in_last
  // result words
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [7:0] out_byte
  input  logic [2:0] out_tuser,  // [0] byte_valid, [1] token_end, [2] string_end
  input  logic       out_tlast,  // run_last
  // configuration writes
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  // totals for the verdict
  output int         fail_count,
  output int         words_pending,
  output int         words_checked
);
  import edt_pkg::*;

  edt_cfg_t tok_cfg;
  logic     esc_held;
  logic     token_live;
  edt_res_t token_words[$];
  edt_res_t want_word;
  int       n_fail = 0;
  int       n_checked = 0;

  function automatic edt_res_t mark_word(input logic [7:0] b, input logic bv,
                                         input logic te, input logic se,
                                         input logic rl);
    edt_res_t w;
    w.out_byte   = b;
    w.byte_valid = bv;
    w.token_end  = te;
    w.string_end = se;
    w.run_last   = rl;
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    n_fail++;
    if (n_fail <= 100) $display("MISMATCH @%0t word %0d: %s", $time, n_checked, what);
  endtask

  // Work out the result words that one string byte gives and queue them
  task automatic tokenize_byte(input logic [7:0] b, input logic fin);
    logic [7:0] run_bytes[2];
    int         nb;
    int         slots;
    logic       hit;
    nb    = 0;
    slots = int'(tok_cfg.delim_count);
    if (slots > MAX_DELIMS) slots = MAX_DELIMS;
    if (slots > NUM_SLOTS) slots = NUM_SLOTS;
    hit = 1'b0;
    for (int i = 0; i < slots; i++)
      if (tok_cfg.delim[i] == b) hit = 1'b1;

    if (slots == 0) begin
      // passthrough: backslash has no meaning
      esc_held     = 1'b0;
      run_bytes[0] = b;
      nb           = 1;
    end else if (b == ESCAPE_BYTE && !esc_held) begin
      if (!fin) begin
        esc_held = 1'b1;
        return;
      end
      // trailing backslash is dropped
      token_words = {token_words, mark_word(8'h00, 1'b0, token_live, 1'b1, 1'b1)};
      esc_held   = 1'b0;
      token_live = 1'b0;
      return;
    end else if (hit && !esc_held) begin
      // bare delimiter: close an open token, suppress empty ones
      if (!token_live && !fin) return;
      token_words = {token_words, mark_word(8'h00, 1'b0, token_live, fin, 1'b1)};
      token_live = 1'b0;
      return;
    end else begin
      // keep the backslash unless it escapes a delimiter in strip mode
      if (esc_held && !(hit && tok_cfg.strip_escape)) begin
        run_bytes[nb] = ESCAPE_BYTE;
        nb++;
      end
      run_bytes[nb] = b;
      nb++;
      esc_held = 1'b0;
    end

    for (int k = 0; k < nb; k++)
      token_words = {token_words,
                     mark_word(run_bytes[k], 1'b1, (k == nb - 1) && fin,
                               (k == nb - 1) && fin, k == nb - 1)};
    token_live = !fin;
    if (fin) esc_held = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tok_cfg.delim        = '0;
      tok_cfg.delim[0]     = DELIM_0_RST;
      tok_cfg.delim_count  = 3'd1;
      tok_cfg.strip_escape = 1'b1;
      esc_held             = 1'b0;
      token_live           = 1'b0;
      token_words.delete();
    end else begin
      // compare the word leaving the block with the oldest prediction
      if (out_tvalid && out_tready) begin
        n_checked++;
        if (token_words.size() == 0) begin
          report_mismatch($sformatf("word with nothing expected: byte %02h user %03b last %b",
                                    out_tdata, out_tuser, out_tlast));
        end else begin
          want_word = token_words.pop_front();
          if (out_tdata !== want_word.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      out_tdata, want_word.out_byte));
          if (out_tuser[0] !== want_word.byte_valid)
            report_mismatch($sformatf("byte_valid %b, expected %b",
                                      out_tuser[0], want_word.byte_valid));
          if (out_tuser[1] !== want_word.token_end)
            report_mismatch($sformatf("token_end %b, expected %b",
                                      out_tuser[1], want_word.token_end));
          if (out_tuser[2] !== want_word.string_end)
            report_mismatch($sformatf("string_end %b, expected %b",
                                      out_tuser[2], want_word.string_end));
          if (out_tlast !== want_word.run_last)
            report_mismatch($sformatf("run_last %b, expected %b",
                                      out_tlast, want_word.run_last));
        end
      end

      // track register writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DELIM_0, REG_DELIM_1, REG_DELIM_2, REG_DELIM_3: begin
            tok_cfg.delim[cfg_index[1:0]] = cfg_data;
          end
          REG_DELIM_COUNT: begin
            tok_cfg.delim_count = cfg_data[2:0];
          end
          REG_STRIP: begin
            tok_cfg.strip_escape = cfg_data[0];
          end
          default: begin
          end
        endcase
      end

      if (in_tvalid && in_tready) tokenize_byte(in_tdata, in_tlast);
    end
    fail_count    <= n_fail;
    words_pending <= token_words.size();
    words_checked <= n_checked;
  end

endmodule

### tb/tb_escaped_delimiter_tokenizer.sv
// Testbench top for the escaped delimiter tokenizer: clock, reset, byte and
// register stimulus, output back-pressure and the verdict.
// Depends on edt_pkg, the tokenizer RTL and edt_token_checker.
module tb_escaped_delimiter_tokenizer;
  import edt_pkg::*;

  localparam int unsigned MAX_DELIMS = MAX_DELIMS_D;
  localparam int PHASE_BYTES     = 57;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int SETTLE_CYCLES   = 8;
  localparam int END_CYCLES      = 20;
  localparam int RUN_LIMIT       = 4_000_000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] in_byte
  logic       in_tlast = 1'b0;    // in_last
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] out_byte
  logic [2:0] out_tuser;          // [0] byte_valid, [1] token_end, [2] string_end
  logic       out_tlast;          // run_last
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = REG_DELIM_0;
  logic [7:0] cfg_data = 8'h00;

  int         fail_count;
  int         words_pending;
  int         words_checked;

  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  logic       hold_req = 1'b0;
  logic [7:0] delim_pick[4] = '{DELIM_0_RST, 8'h00, 8'h00, 8'h00};
  int         bytes_sent = 0;
  int         strings_sent = 0;
  int         settings_run = 1;
  int         holds_done = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  escaped_delimiter_tokenizer #(.MAX_DELIMS(MAX_DELIMS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  edt_token_checker #(.MAX_DELIMS(MAX_DELIMS)) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .words_pending(words_pending), .words_checked(words_checked)
  );

  // Output back-pressure: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req   <= 1'b0;
        out_tready <= 1'b0;
        for (int c = 1; c < HOLD_OFF_CYCLES; c++) @(posedge clk);
        holds_done++;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one byte after a random gap and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    strings_sent++;
  endtask

  // Mostly delimiters, backslashes and letters, with some fully random bytes
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 25) return delim_pick[$urandom_range(3)];
    if (r < 40) return ESCAPE_BYTE;
    if (r < 55) return 8'($urandom_range(255));
    return 8'($urandom_range(8'h7A, 8'h61));
  endfunction

  task automatic send_string();
    int len;
    len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(10, 1);
    for (int i = 0; i < len; i++) send_byte(pick_byte(), i == len - 1);
    strings_sent++;
  endtask

  task automatic send_strings(input int n_bytes, input int send_pct, input int recv_pct);
    int goal;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    goal           = bytes_sent + n_bytes;
    while (bytes_sent < goal) send_string();
  endtask

  // Hold the byte channel until every predicted word has left the block
  task automatic drain_words();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
  endtask

  task automatic settle();
    drain_words();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [7:0] d0, input logic [7:0] d1, input logic [7:0] d2,
                           input logic [7:0] d3, input logic [2:0] cnt, input logic strip);
    write_reg(REG_DELIM_0, d0);
    write_reg(REG_DELIM_1, d1);
    write_reg(REG_DELIM_2, d2);
    write_reg(REG_DELIM_3, d3);
    write_reg(REG_DELIM_COUNT, {5'd0, cnt});
    write_reg(REG_STRIP, {7'd0, strip});
    cfg_valid  <= 1'b0;
    delim_pick = '{d0, d1, d2, d3};
    settings_run++;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: lone final delimiter, empty tokens, escapes, trailing backslash
    send_text(";");
    send_text("ab;;\\;c\\\\\\q;\\");
    send_text("z\\");
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(";", 1'b1);
    strings_sent++;
    send_text("\\;");
    send_strings(PHASE_BYTES - 21, 0, 0);
    settle();

    // All four slots, backslash kept before escaped delimiters, sender idling
    configure(";", ",", " ", 8'h09, 3'd4, 1'b0);
    send_strings(PHASE_BYTES, 82, 0);
    settle();

    // Byte extremes and backslash as delimiters, count above the slot limit
    configure(8'h00, 8'hFF, ESCAPE_BYTE, ":", 3'd7, 1'b1);
    send_strings(PHASE_BYTES, 0, 82);
    settle();

    // No delimiters: raw passthrough
    configure(",", ";", 8'h00, 8'hFF, 3'd0, 1'b0);
    send_strings(PHASE_BYTES, 17, 17);
    settle();

    // Long output hold-off while bytes keep coming, then a full drain mid-phase
    configure(8'($urandom_range(255)), ";", 8'($urandom_range(255)), 8'h00, 3'd2, 1'b1);
    hold_req <= 1'b1;
    send_strings(PHASE_BYTES / 2, 0, 0);
    drain_words();
    send_strings(PHASE_BYTES - PHASE_BYTES / 2, 0, 0);
    settle();

    // Random delimiters and random strip mode
    configure(8'($urandom_range(255)), 8'($urandom_range(255)), ESCAPE_BYTE,
              8'($urandom_range(255)), 3'd3, 1'($urandom_range(1)));
    send_strings(PHASE_BYTES, 0, 82);
    settle();

    configure(";", 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 3'd5, 1'($urandom_range(1)));
    send_strings(PHASE_BYTES, 82, 0);

    drain_words();
    repeat (END_CYCLES) @(posedge clk);
    $display("Sent %0d string bytes in %0d strings over %0d register settings, %0d long hold-off(s).",
             bytes_sent, strings_sent, settings_run, holds_done);
    $display("Compared %0d result words, %0d mismatch(es).", words_checked, fail_count);
    if (fail_count == 0 && words_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #(RUN_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/edt_pkg.sv
rtl/edt_cfg.sv
rtl/edt_core.sv
rtl/edt_fifo.sv
rtl/escaped_delimiter_tokenizer.sv
tb/edt_token_checker.sv
tb/tb_escaped_delimiter_tokenizer.sv
